// File: sv/dccp_pkg.sv
// Shared types, constants and helper function for the detector cell corner projector.
`default_nettype none

package dccp_pkg;

	// Grid size defaults and the index width that covers the largest grid.
	localparam int DEF_CELLS_X = 128;
	localparam int DEF_CELLS_Y = 128;
	localparam int IDX_W       = 10;

	// Cell corner inset of 0.02 cm in Q16.16.
	localparam int INSET_Q16 = 1311;

	// Gap pattern: rows repeat every 11 with 8 active, columns every 18 with 16 active.
	localparam int ROW_PERIOD = 11;
	localparam int ROW_ACTIVE = 7;
	localparam int COL_PERIOD = 18;
	localparam int COL_ACTIVE = 15;

	// Reciprocal multipliers for the remainder by 11 and by 18 on index-sized values.
	localparam int MOD_SHIFT = 18;
	localparam int MUL_11    = 23832;
	localparam int MUL_18    = 14564;

	// Divider operand widths: ratio dividends reach 2^50, divisors 2^34.
	localparam int DIV_NW = 50;
	localparam int DIV_DW = 34;

	// Depth of the job queue and of the result queue.
	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_POLY = 2'd0,
		KIND_DONE = 2'd1,
		KIND_OVER = 2'd2,
		KIND_ZDEN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		JOB_WALK,
		JOB_ZDEN,
		JOB_NOPOLY
	} job_kind_t;

	typedef struct packed {
		logic [30:0]        cx;    // effective pitch, never zero
		logic [30:0]        cy;
		logic signed [31:0] gox;
		logic signed [31:0] goy;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic [5:0]         maxp;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] box_x_min;
		logic signed [31:0] box_x_max;
		logic signed [31:0] box_y_min;
		logic signed [31:0] box_y_max;
		logic signed [31:0] plane_z;
	} req_t;

	typedef struct packed {
		job_kind_t          kind;
		logic               empty;
		logic signed [31:0] rat;
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic [IDX_W-1:0]   imin;
		logic [IDX_W-1:0]   imax;
		logic [IDX_W-1:0]   jmin;
		logic [IDX_W-1:0]   jmax;
		logic [4:0]         imod;
		logic [3:0]         jmod;
		logic signed [43:0] xb0;
		logic signed [43:0] yb0;
	} job_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] c0x;
		logic signed [31:0] c1x;
		logic signed [31:0] c2x;
		logic signed [31:0] c3x;
		logic signed [31:0] c0y;
		logic signed [31:0] c1y;
		logic signed [31:0] c2y;
		logic signed [31:0] c3y;
		logic [5:0]         count;
		logic               last;
	} res_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/dccp_fifo.sv
// Small synchronous queue used for the job hand-off and for the result port.
`default_nettype none

module dccp_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  T     wdata,
	output logic full,
	input  wire  pop,
	output T     rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/dccp_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module dccp_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [dccp_pkg::DIV_NW-1:0] dividend,
	input  wire [dccp_pkg::DIV_DW-1:0] divisor,
	output logic [dccp_pkg::DIV_NW-1:0] quo,
	output logic                       rem_nz,
	output logic                       done
);
	import dccp_pkg::*;

	localparam int CW = $clog2(DIV_NW);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;

	assign trial  = {rem_q, quo_q[DIV_NW-1]};
	assign diff   = trial - {1'b0, dvs_q};
	assign quo    = quo_q;
	assign rem_nz = (rem_q != '0);
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!diff[DIV_DW]) begin
				rem_q <= diff[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end else if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end
	end

endmodule

`default_nettype wire

// File: sv/dccp_front.sv
// Request front end: ratios, projected box, clamped cell range and walk start values.
`default_nettype none

module dccp_front #(
	parameter int CELLS_X = dccp_pkg::DEF_CELLS_X,
	parameter int CELLS_Y = dccp_pkg::DEF_CELLS_Y
) (
	input  wire                clk,
	input  wire                arst_n,
	input  dccp_pkg::cfg_t     cfg,
	input  wire                push,
	input  dccp_pkg::req_t     req,
	output logic               full,
	output logic               job_push,
	output dccp_pkg::job_t     job,
	input  wire                job_full
);
	import dccp_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_CHK, F_DSTART, F_DWAIT, F_BOXD, F_BOXM, F_BOXS, F_CLAMP, F_BASE, F_PUSH
	} fstate_t;

	fstate_t            state_q;
	logic [2:0]         op_q;
	req_t               req_q;
	job_t               job_q;
	logic signed [31:0] q_q;
	logic signed [31:0] bd_q [4];
	logic signed [63:0] bp_q [4];
	logic signed [49:0] a_q [4];
	logic signed [50:0] rng_q [4];
	logic [IDX_W-1:0]   imin_q;
	logic [IDX_W-1:0]   jmin_q;

	logic signed [32:0] zs, zd, zp;
	logic signed [32:0] rnum, rden;
	logic [32:0]        rnum_abs, rden_abs;
	logic               rneg;
	logic [1:0]         aidx;
	logic signed [49:0] acur;
	logic [49:0]        acur_abs;
	logic [DIV_NW-1:0]  dividend;
	logic [DIV_DW-1:0]  divisor;
	logic [DIV_NW-1:0]  quo;
	logic               rem_nz;
	logic               div_done;
	logic signed [31:0] ratio;
	logic signed [50:0] qs, rfloor, rceil;
	logic signed [31:0] bsel [4];
	logic signed [31:0] ssel [4];
	logic signed [31:0] osel [4];
	logic signed [50:0] xlo, xhi, ylo, yhi;
	logic [IDX_W+14:0]  mx, my;
	logic [IDX_W-1:0]   qx, qy, rx, ry;
	logic [40:0]        xprod, yprod;

	assign zs = 33'(req_q.src_z) - 33'(cfg.bz);
	assign zd = 33'(req_q.plane_z) - 33'(cfg.bz);
	assign zp = 33'(req_q.src_z) - 33'(req_q.plane_z);

	// Operand selection for the shared divider.
	assign rnum     = zd;
	assign rden     = op_q[0] ? zp : zs;
	assign rnum_abs = rnum[32] ? 33'(-rnum) : 33'(rnum);
	assign rden_abs = rden[32] ? 33'(-rden) : 33'(rden);
	assign rneg     = (rnum[32] != rden[32]) && (rnum != '0);
	assign aidx     = 2'(op_q - 3'd2);
	assign acur     = a_q[aidx];
	assign acur_abs = acur[49] ? 50'(-acur) : 50'(acur);

	always_comb begin
		if (op_q < 3'd2) begin
			// Rounded ratio: floor((2n + d) / 2d) with n = |num| << 16.
			dividend = {rnum_abs, 17'b0} + 50'(rden_abs);
			divisor  = {rden_abs, 1'b0};
		end else begin
			dividend = acur_abs;
			divisor  = (op_q < 3'd4) ? 34'(cfg.cx) : 34'(cfg.cy);
		end
	end

	dccp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == F_DSTART),
		.dividend (dividend),
		.divisor  (divisor),
		.quo      (quo),
		.rem_nz   (rem_nz),
		.done     (div_done)
	);

	// Saturated signed ratio from the unsigned quotient.
	always_comb begin
		if (rneg) begin
			ratio = (quo >= 50'h80000000) ? 32'sh80000000 : 32'(-$signed({1'b0, quo[30:0]}));
		end else begin
			ratio = (quo >= 50'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed({1'b0, quo[30:0]});
		end
	end

	assign qs     = $signed({1'b0, quo});
	assign rfloor = acur[49] ? -(qs + 51'(rem_nz)) : qs;
	assign rceil  = (!acur[49] && acur != '0) ? qs + 51'(rem_nz) : -qs;

	assign bsel[0] = req_q.box_x_min;
	assign bsel[1] = req_q.box_x_max;
	assign bsel[2] = req_q.box_y_min;
	assign bsel[3] = req_q.box_y_max;
	assign ssel[0] = req_q.src_x;
	assign ssel[1] = req_q.src_x;
	assign ssel[2] = req_q.src_y;
	assign ssel[3] = req_q.src_y;
	assign osel[0] = cfg.gox;
	assign osel[1] = cfg.gox;
	assign osel[2] = cfg.goy;
	assign osel[3] = cfg.goy;

	assign xlo = rng_q[0][50] ? '0 : rng_q[0];
	assign xhi = (rng_q[1] > 51'(CELLS_X - 1)) ? 51'(CELLS_X - 1) : rng_q[1];
	assign ylo = rng_q[2][50] ? '0 : rng_q[2];
	assign yhi = (rng_q[3] > 51'(CELLS_Y - 1)) ? 51'(CELLS_Y - 1) : rng_q[3];

	// Start phase in the gap pattern by reciprocal multiplication.
	assign mx    = (IDX_W + 15)'(imin_q) * (IDX_W + 15)'(MUL_18);
	assign my    = (IDX_W + 15)'(jmin_q) * (IDX_W + 15)'(MUL_11);
	assign qx    = IDX_W'(mx >> MOD_SHIFT);
	assign qy    = IDX_W'(my >> MOD_SHIFT);
	assign rx    = imin_q - IDX_W'(qx * IDX_W'(COL_PERIOD));
	assign ry    = jmin_q - IDX_W'(qy * IDX_W'(ROW_PERIOD));
	assign xprod = 41'(imin_q) * 41'(cfg.cx);
	assign yprod = 41'(jmin_q) * 41'(cfg.cy);

	assign full     = (state_q != F_IDLE);
	assign job_push = (state_q == F_PUSH) && !job_full;
	assign job      = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			op_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_CHK;
					end
				end
				F_CHK: begin
					op_q <= '0;
					if (zs == '0 || zp == '0 || cfg.maxp == '0) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_DSTART;
					end
				end
				F_DSTART: state_q <= F_DWAIT;
				F_DWAIT: begin
					if (div_done) begin
						op_q <= op_q + 3'd1;
						if (op_q == 3'd1) begin
							state_q <= F_BOXD;
						end else if (op_q == 3'd5) begin
							state_q <= F_CLAMP;
						end else begin
							state_q <= F_DSTART;
						end
					end
				end
				F_BOXD:  state_q <= F_BOXM;
				F_BOXM:  state_q <= F_BOXS;
				F_BOXS:  state_q <= F_DSTART;
				F_CLAMP: state_q <= F_BASE;
				F_BASE:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push) begin
					req_q <= req;
				end
			end
			F_CHK: begin
				job_q.src_x <= req_q.src_x;
				job_q.src_y <= req_q.src_y;
				job_q.empty <= 1'b0;
				if (zs == '0 || zp == '0) begin
					job_q.kind <= JOB_ZDEN;
				end else if (cfg.maxp == '0) begin
					job_q.kind <= JOB_NOPOLY;
				end else begin
					job_q.kind <= JOB_WALK;
				end
			end
			F_DWAIT: begin
				if (div_done) begin
					if (op_q == 3'd0) begin
						job_q.rat <= ratio;
					end else if (op_q == 3'd1) begin
						q_q <= ratio;
					end else begin
						rng_q[aidx] <= op_q[0] ? rceil : rfloor;
					end
				end
			end
			F_BOXD: begin
				for (int k = 0; k < 4; k++) begin
					bd_q[k] <= sat32(64'(ssel[k]) - 64'(bsel[k]));
				end
			end
			F_BOXM: begin
				for (int k = 0; k < 4; k++) begin
					bp_q[k] <= bd_q[k] * q_q;
				end
			end
			F_BOXS: begin
				for (int k = 0; k < 4; k++) begin
					a_q[k] <= 50'(bsel[k]) - 50'(bp_q[k] >>> 16) - 50'(osel[k]);
				end
			end
			F_CLAMP: begin
				job_q.empty <= (xlo > xhi) || (ylo > yhi);
				imin_q      <= IDX_W'(xlo);
				jmin_q      <= IDX_W'(ylo);
				job_q.imin  <= IDX_W'(xlo);
				job_q.imax  <= IDX_W'(xhi);
				job_q.jmin  <= IDX_W'(ylo);
				job_q.jmax  <= IDX_W'(yhi);
			end
			F_BASE: begin
				job_q.imod <= 5'(rx);
				job_q.jmod <= 4'(ry);
				job_q.xb0  <= $signed(44'(xprod)) + 44'(cfg.gox) + 44'(cfg.bx);
				job_q.yb0  <= $signed(44'(yprod)) + 44'(cfg.goy) + 44'(cfg.by);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/dccp_back.sv
// Back end: walks the cell range, projects four corners per cell and writes result items.
`default_nettype none

module dccp_back (
	input  wire                clk,
	input  wire                arst_n,
	input  dccp_pkg::cfg_t     cfg,
	input  wire                job_empty,
	input  dccp_pkg::job_t     job,
	output logic               job_pop,
	output logic               res_push,
	output dccp_pkg::res_t     res,
	input  wire                res_full
);
	import dccp_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE, B_CELL, B_DIFF, B_MUL, B_SUM, B_STAT
	} bstate_t;

	bstate_t            state_q;
	job_t               job_q;
	kind_t              stat_kind_q;
	logic [5:0]         n_q;
	logic [IDX_W-1:0]   i_q, j_q;
	logic [4:0]         im_q;
	logic [3:0]         jm_q;
	logic signed [43:0] xb_q, yb_q;
	logic signed [31:0] dx0_q, dx1_q, dy0_q, dy1_q;
	logic signed [63:0] px0_q, px1_q, py0_q, py1_q;

	logic signed [31:0] px, py;
	logic               col_gap, row_gap, col_step, row_step;
	logic signed [31:0] cx0, cx1, cy0, cy1;
	res_t               res_d;

	assign px = $signed({1'b0, cfg.cx}) - 32'(INSET_Q16);
	assign py = $signed({1'b0, cfg.cy}) - 32'(INSET_Q16);

	assign row_gap  = (jm_q > 4'(ROW_ACTIVE));
	assign col_gap  = (im_q > 5'(COL_ACTIVE));
	assign col_step = (state_q == B_CELL && !row_gap && col_gap) ||
			(state_q == B_SUM && !res_full);
	assign row_step = (state_q == B_CELL && row_gap) || (col_step && i_q == job_q.imax);

	// Final add of each corner: base plus offset plus the rounded product.
	assign cx0 = sat32(64'(xb_q) + ((px0_q + 64'sd32768) >>> 16));
	assign cx1 = sat32(64'(xb_q) + 64'(px) + ((px1_q + 64'sd32768) >>> 16));
	assign cy0 = sat32(64'(yb_q) + ((py0_q + 64'sd32768) >>> 16));
	assign cy1 = sat32(64'(yb_q) + 64'(py) + ((py1_q + 64'sd32768) >>> 16));

	always_comb begin
		res_d = '0;
		if (state_q == B_SUM) begin
			res_d.kind  = KIND_POLY;
			res_d.c0x   = cx0;
			res_d.c1x   = cx0;
			res_d.c2x   = cx1;
			res_d.c3x   = cx1;
			res_d.c0y   = cy0;
			res_d.c1y   = cy1;
			res_d.c2y   = cy1;
			res_d.c3y   = cy0;
			res_d.count = n_q + 6'd1;
			res_d.last  = 1'b0;
		end else begin
			res_d.kind  = stat_kind_q;
			res_d.count = n_q;
			res_d.last  = 1'b1;
		end
	end

	assign res      = res_d;
	assign res_push = (state_q == B_SUM || state_q == B_STAT) && !res_full;
	assign job_pop  = (state_q == B_IDLE) && !job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			n_q         <= '0;
			stat_kind_q <= KIND_DONE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						n_q <= '0;
						if (job.kind == JOB_ZDEN) begin
							stat_kind_q <= KIND_ZDEN;
							state_q     <= B_STAT;
						end else if (job.kind == JOB_NOPOLY) begin
							stat_kind_q <= KIND_OVER;
							state_q     <= B_STAT;
						end else if (job.empty) begin
							stat_kind_q <= KIND_DONE;
							state_q     <= B_STAT;
						end else begin
							state_q <= B_CELL;
						end
					end
				end
				B_CELL: begin
					if (!row_gap && !col_gap) begin
						if (n_q >= cfg.maxp) begin
							stat_kind_q <= KIND_OVER;
							state_q     <= B_STAT;
						end else begin
							state_q <= B_DIFF;
						end
					end
				end
				B_DIFF: state_q <= B_MUL;
				B_MUL:  state_q <= B_SUM;
				B_SUM: begin
					if (!res_full) begin
						n_q <= n_q + 6'd1;
					end
				end
				B_STAT: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			// Walk stepping overrides the per-state transition.
			if (row_step) begin
				if (j_q == job_q.jmax) begin
					stat_kind_q <= KIND_DONE;
					state_q     <= B_STAT;
				end else begin
					state_q <= B_CELL;
				end
			end else if (col_step) begin
				state_q <= B_CELL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !job_empty) begin
			job_q <= job;
			i_q   <= job.imin;
			j_q   <= job.jmin;
			im_q  <= job.imod;
			jm_q  <= job.jmod;
			xb_q  <= job.xb0;
			yb_q  <= job.yb0;
		end else if (row_step) begin
			j_q  <= j_q + 1'b1;
			jm_q <= (jm_q == 4'(ROW_PERIOD - 1)) ? '0 : jm_q + 4'd1;
			yb_q <= yb_q + 44'(cfg.cy);
			i_q  <= job_q.imin;
			im_q <= job_q.imod;
			xb_q <= job_q.xb0;
		end else if (col_step) begin
			i_q  <= i_q + 1'b1;
			im_q <= (im_q == 5'(COL_PERIOD - 1)) ? '0 : im_q + 5'd1;
			xb_q <= xb_q + 44'(cfg.cx);
		end
		if (state_q == B_DIFF) begin
			dx0_q <= sat32(64'(job_q.src_x) - 64'(xb_q));
			dx1_q <= sat32(64'(job_q.src_x) - 64'(xb_q) - 64'(px));
			dy0_q <= sat32(64'(job_q.src_y) - 64'(yb_q));
			dy1_q <= sat32(64'(job_q.src_y) - 64'(yb_q) - 64'(py));
		end
		if (state_q == B_MUL) begin
			px0_q <= dx0_q * job_q.rat;
			px1_q <= dx1_q * job_q.rat;
			py0_q <= dy0_q * job_q.rat;
			py1_q <= dy1_q * job_q.rat;
		end
	end

endmodule

`default_nettype wire

// File: sv/detector_cell_corner_projector.sv
// Top level of the detector cell corner projector: registers, front, both queues, back.
`default_nettype none

// Usage. Requests enter on a queue-style channel: a transfer happens at a rising
// edge with push high and full low, carrying the source position, the bounding
// box and the plane height. Results leave on a second queue-style channel: the
// oldest result sits on the result ports while empty is low and is taken by a
// transfer with pop high. Each request yields zero or more polygon items
// (kind 0) followed by one status item with last high.
// The front end runs six divisions on one shared 50-step restoring divider
// plus checks and hand-off, and is busy (full high) until its job is handed
// off, so it takes no new request meanwhile. For each emitted polygon the back
// end passes through its cell, difference, product and sum states; it also
// steps over gap columns and gap rows, and ends each job with the status item.
// The job queue lets the front work on the next request while the back end
// still walks the previous one.
// When the receiver stalls, the result queue fills, the back end holds its
// walk, then the job queue and finally the front end hold in turn; nothing is
// dropped. Reset empties both queues and returns the registers to their
// defaults. Registers sit at byte address 4*index on the APB port and may be
// changed only while the block is idle.
module detector_cell_corner_projector #(
	parameter int CELLS_X = dccp_pkg::DEF_CELLS_X,
	parameter int CELLS_Y = dccp_pkg::DEF_CELLS_Y
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         push,
	output logic        full,
	input  wire  [31:0] src_x,
	input  wire  [31:0] src_y,
	input  wire  [31:0] src_z,
	input  wire  [31:0] box_x_min,
	input  wire  [31:0] box_x_max,
	input  wire  [31:0] box_y_min,
	input  wire  [31:0] box_y_max,
	input  wire  [31:0] plane_z,
	output logic        empty,
	input  wire         pop,
	output logic [1:0]  kind,
	output logic [31:0] corner0_x,
	output logic [31:0] corner1_x,
	output logic [31:0] corner2_x,
	output logic [31:0] corner3_x,
	output logic [31:0] corner0_y,
	output logic [31:0] corner1_y,
	output logic [31:0] corner2_y,
	output logic [31:0] corner3_y,
	output logic [5:0]  poly_count,
	output logic        last
);
	import dccp_pkg::*;

	typedef enum logic [2:0] {
		REG_CELL_SIZE_X  = 3'd0,
		REG_CELL_SIZE_Y  = 3'd1,
		REG_GRID_ORIG_X  = 3'd2,
		REG_GRID_ORIG_Y  = 3'd3,
		REG_BLOCK_OFF_X  = 3'd4,
		REG_BLOCK_OFF_Y  = 3'd5,
		REG_BLOCK_OFF_Z  = 3'd6,
		REG_MAX_POLYGONS = 3'd7
	} reg_idx_t;

	logic [30:0] csx_q, csy_q;
	logic [31:0] gox_q, goy_q, bx_q, by_q, bz_q;
	logic [5:0]  maxp_q;
	logic        wr_en;
	reg_idx_t    widx;
	cfg_t        cfg;
	req_t        req;
	job_t        fjob, bjob;
	logic        fjob_push, job_full, job_empty, job_pop;
	res_t        bres, ores;
	logic        res_push, res_full;

	// The APB port never waits; a write lands in the access cycle.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csx_q  <= 31'd65536;
			csy_q  <= 31'd65536;
			gox_q  <= '0;
			goy_q  <= '0;
			bx_q   <= '0;
			by_q   <= '0;
			bz_q   <= '0;
			maxp_q <= 6'd63;
		end else if (wr_en) begin
			unique case (widx)
				REG_CELL_SIZE_X:  csx_q  <= pwdata[30:0];
				REG_CELL_SIZE_Y:  csy_q  <= pwdata[30:0];
				REG_GRID_ORIG_X:  gox_q  <= pwdata;
				REG_GRID_ORIG_Y:  goy_q  <= pwdata;
				REG_BLOCK_OFF_X:  bx_q   <= pwdata;
				REG_BLOCK_OFF_Y:  by_q   <= pwdata;
				REG_BLOCK_OFF_Z:  bz_q   <= pwdata;
				REG_MAX_POLYGONS: maxp_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_CELL_SIZE_X:  prdata = {1'b0, csx_q};
			REG_CELL_SIZE_Y:  prdata = {1'b0, csy_q};
			REG_GRID_ORIG_X:  prdata = gox_q;
			REG_GRID_ORIG_Y:  prdata = goy_q;
			REG_BLOCK_OFF_X:  prdata = bx_q;
			REG_BLOCK_OFF_Y:  prdata = by_q;
			REG_BLOCK_OFF_Z:  prdata = bz_q;
			REG_MAX_POLYGONS: prdata = {26'b0, maxp_q};
			default:          prdata = '0;
		endcase
	end

	// A pitch of zero is treated as a pitch of one.
	assign cfg.cx   = (csx_q == '0) ? 31'd1 : csx_q;
	assign cfg.cy   = (csy_q == '0) ? 31'd1 : csy_q;
	assign cfg.gox  = gox_q;
	assign cfg.goy  = goy_q;
	assign cfg.bx   = bx_q;
	assign cfg.by   = by_q;
	assign cfg.bz   = bz_q;
	assign cfg.maxp = maxp_q;

	assign req.src_x     = src_x;
	assign req.src_y     = src_y;
	assign req.src_z     = src_z;
	assign req.box_x_min = box_x_min;
	assign req.box_x_max = box_x_max;
	assign req.box_y_min = box_y_min;
	assign req.box_y_max = box_y_max;
	assign req.plane_z   = plane_z;

	dccp_front #(
		.CELLS_X (CELLS_X),
		.CELLS_Y (CELLS_Y)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.req      (req),
		.full     (full),
		.job_push (fjob_push),
		.job      (fjob),
		.job_full (job_full)
	);

	// Job queue between the front end and the cell walker.
	dccp_fifo #(
		.T     (job_t),
		.DEPTH (Q_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fjob_push),
		.wdata  (fjob),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (bjob),
		.empty  (job_empty)
	);

	dccp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_empty (job_empty),
		.job       (bjob),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res       (bres),
		.res_full  (res_full)
	);

	// Result queue: keeps the walker running while the receiver holds off.
	dccp_fifo #(
		.T     (res_t),
		.DEPTH (Q_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (bres),
		.full   (res_full),
		.pop    (pop),
		.rdata  (ores),
		.empty  (empty)
	);

	assign kind       = ores.kind;
	assign corner0_x  = ores.c0x;
	assign corner1_x  = ores.c1x;
	assign corner2_x  = ores.c2x;
	assign corner3_x  = ores.c3x;
	assign corner0_y  = ores.c0y;
	assign corner1_y  = ores.c1y;
	assign corner2_y  = ores.c2y;
	assign corner3_y  = ores.c3y;
	assign poly_count = ores.count;
	assign last       = ores.last;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the detector cell corner projector.
`default_nettype none

module tb_top;
	import dccp_pkg::*;

	// Total number of clock cycles before the run is declared hung. The front
	// end divides serially for each request and results trickle out under heavy
	// receiver stalls, so this leaves a wide margin over the slowest good run.
	localparam int CYCLE_LIMIT = 2000000;
	localparam int GRID_X = 128;
	localparam int GRID_Y = 128;

	// Register indexes in the order of the register map.
	localparam int REG_CELL_X = 0;
	localparam int REG_CELL_Y = 1;
	localparam int REG_ORIG_X = 2;
	localparam int REG_ORIG_Y = 3;
	localparam int REG_OFFS_X = 4;
	localparam int REG_OFFS_Y = 5;
	localparam int REG_OFFS_Z = 6;
	localparam int REG_MAXP   = 7;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push, full, empty, pop;
	req_t        drv;
	logic [1:0]  kind;
	logic [31:0] corner0_x, corner1_x, corner2_x, corner3_x;
	logic [31:0] corner0_y, corner1_y, corner2_y, corner3_y;
	logic [5:0]  poly_count;
	logic        last;

	// Our own copy of the register file, used by the projection predictor.
	logic [30:0] pitch_x, pitch_y;
	logic signed [31:0] origin_x, origin_y, offset_x, offset_y, offset_z;
	logic [5:0]  poly_limit;

	req_t requests_to_send[$];
	res_t expected_results[$];
	bit   req_taken;
	int   send_idle_pct, recv_idle_pct;
	int   mismatches;
	int   cycles;

	detector_cell_corner_projector uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.src_x(drv.src_x), .src_y(drv.src_y), .src_z(drv.src_z),
		.box_x_min(drv.box_x_min), .box_x_max(drv.box_x_max),
		.box_y_min(drv.box_y_min), .box_y_max(drv.box_y_max),
		.plane_z(drv.plane_z),
		.empty(empty), .pop(pop), .kind(kind),
		.corner0_x(corner0_x), .corner1_x(corner1_x),
		.corner2_x(corner2_x), .corner3_x(corner3_x),
		.corner0_y(corner0_y), .corner1_y(corner1_y),
		.corner2_y(corner2_y), .corner3_y(corner3_y),
		.poly_count(poly_count), .last(last)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Q16.16 quotient rounded to nearest with ties away from zero, clipped.
	function automatic longint q16_quotient(longint num, longint den);
		bit     neg;
		longint n, d, q;
		neg = (num < 0) != (den < 0);
		n = (num < 0 ? -num : num) * 65536;
		d = den < 0 ? -den : den;
		q = (2 * n + d) / (2 * d);
		if (q > 64'sd4294967296) begin
			q = 64'sd4294967296;
		end
		return clip32(neg ? -q : q);
	endfunction

	function automatic longint div_floor(longint a, longint b);
		longint q;
		q = a / b;
		if (a % b != 0 && a < 0) begin
			q--;
		end
		return q;
	endfunction

	function automatic longint div_ceil(longint a, longint b);
		longint q;
		q = a / b;
		if (a % b != 0 && a > 0) begin
			q++;
		end
		return q;
	endfunction

	// One corner coordinate pulled from the cell edge toward the source.
	// The product is rounded with ties toward plus infinity.
	function automatic logic [31:0] project_corner(longint base, longint off,
			longint src, longint ratio);
		longint d, t;
		d = clip32(src - base - off);
		t = (d * ratio + 32768) >>> 16;
		return clip32(base + off + t);
	endfunction

	function automatic res_t status_item(kind_t k, int n);
		res_t r;
		r = '0;
		r.kind = k;
		r.count = n[5:0];
		r.last = 1'b1;
		return r;
	endfunction

	// Works out every polygon and the closing status of one request.
	task automatic project_request(req_t rq);
		longint sxp, syp, szp, pz, cx, cy, px, py, zs, zd, zp, ratio, q;
		longint lox, hix, loy, hiy, imin, imax, jmin, jmax, xb, yb;
		int     n;
		res_t   r;
		sxp = rq.src_x;
		syp = rq.src_y;
		szp = rq.src_z;
		pz = rq.plane_z;
		cx = pitch_x == 0 ? 1 : longint'(pitch_x);
		cy = pitch_y == 0 ? 1 : longint'(pitch_y);
		px = cx - INSET_Q16;
		py = cy - INSET_Q16;
		zs = szp - offset_z;
		zd = pz - offset_z;
		zp = szp - pz;
		n = 0;
		if (zs == 0 || zp == 0) begin
			expected_results.push_back(status_item(KIND_ZDEN, 0));
			return;
		end
		if (poly_limit == 0) begin
			expected_results.push_back(status_item(KIND_OVER, 0));
			return;
		end
		ratio = q16_quotient(zd, zs);
		q = q16_quotient(zd, zp);
		lox = longint'(rq.box_x_min) - ((clip32(sxp - rq.box_x_min) * q) >>> 16);
		hix = longint'(rq.box_x_max) - ((clip32(sxp - rq.box_x_max) * q) >>> 16);
		loy = longint'(rq.box_y_min) - ((clip32(syp - rq.box_y_min) * q) >>> 16);
		hiy = longint'(rq.box_y_max) - ((clip32(syp - rq.box_y_max) * q) >>> 16);
		imin = div_floor(lox - origin_x, cx);
		imax = div_ceil(hix - origin_x, cx);
		jmin = div_floor(loy - origin_y, cy);
		jmax = div_ceil(hiy - origin_y, cy);
		if (imin < 0) imin = 0;
		if (jmin < 0) jmin = 0;
		if (imax > GRID_X - 1) imax = GRID_X - 1;
		if (jmax > GRID_Y - 1) jmax = GRID_Y - 1;
		for (longint j = jmin; j <= jmax; j++) begin
			if (j % ROW_PERIOD > ROW_ACTIVE) continue;
			yb = j * cy + origin_y + offset_y;
			for (longint i = imin; i <= imax; i++) begin
				if (i % COL_PERIOD > COL_ACTIVE) continue;
				// Another active cell with the budget used up ends the walk.
				if (n >= poly_limit) begin
					expected_results.push_back(status_item(KIND_OVER, n));
					return;
				end
				xb = i * cx + origin_x + offset_x;
				r = '0;
				r.kind = KIND_POLY;
				r.c0x = project_corner(xb, 0, sxp, ratio);
				r.c1x = r.c0x;
				r.c2x = project_corner(xb, px, sxp, ratio);
				r.c3x = r.c2x;
				r.c0y = project_corner(yb, 0, syp, ratio);
				r.c1y = project_corner(yb, py, syp, ratio);
				r.c2y = r.c1y;
				r.c3y = r.c0y;
				n++;
				r.count = n[5:0];
				expected_results.push_back(r);
			end
		end
		expected_results.push_back(status_item(KIND_DONE, n));
	endtask

	// Sender side: a new request goes out at the falling edge once the
	// previous transfer has happened, unless this cycle is an idle one.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (!(push && !req_taken)) begin
				if (requests_to_send.size() != 0
						&& $urandom_range(99) >= send_idle_pct) begin
					drv <= requests_to_send.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= $urandom_range(99) >= recv_idle_pct;
		end
		req_taken = 1'b0;
	end

	// Both transfers are observed at the rising edge. An accepted request is
	// predicted at once; an accepted result is checked against the oldest
	// expectation.
	always @(posedge clk) begin
		res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && push && !full) begin
			project_request(drv);
			req_taken = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d", kind);
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				if (kind != e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind);
					mismatches++;
				end
				if (corner0_x != e.c0x) begin
					$error("corner0_x: expected %h, got %h", e.c0x, corner0_x);
					mismatches++;
				end
				if (corner1_x != e.c1x) begin
					$error("corner1_x: expected %h, got %h", e.c1x, corner1_x);
					mismatches++;
				end
				if (corner2_x != e.c2x) begin
					$error("corner2_x: expected %h, got %h", e.c2x, corner2_x);
					mismatches++;
				end
				if (corner3_x != e.c3x) begin
					$error("corner3_x: expected %h, got %h", e.c3x, corner3_x);
					mismatches++;
				end
				if (corner0_y != e.c0y) begin
					$error("corner0_y: expected %h, got %h", e.c0y, corner0_y);
					mismatches++;
				end
				if (corner1_y != e.c1y) begin
					$error("corner1_y: expected %h, got %h", e.c1y, corner1_y);
					mismatches++;
				end
				if (corner2_y != e.c2y) begin
					$error("corner2_y: expected %h, got %h", e.c2y, corner2_y);
					mismatches++;
				end
				if (corner3_y != e.c3y) begin
					$error("corner3_y: expected %h, got %h", e.c3y, corner3_y);
					mismatches++;
				end
				if (poly_count != e.count) begin
					$error("poly_count: expected %0d, got %0d", e.count, poly_count);
					mismatches++;
				end
				if (last != e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					mismatches++;
				end
			end
		end
	end

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the rising edge inside the access cycle. The predictor copy follows.
	task automatic write_reg(int idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CELL_X: pitch_x = value[30:0];
			REG_CELL_Y: pitch_y = value[30:0];
			REG_ORIG_X: origin_x = value;
			REG_ORIG_Y: origin_y = value;
			REG_OFFS_X: offset_x = value;
			REG_OFFS_Y: offset_y = value;
			REG_OFFS_Z: offset_z = value;
			REG_MAXP:   poly_limit = value[5:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] gx,
			logic [31:0] gy, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] mp);
		write_reg(REG_CELL_X, cx);
		write_reg(REG_CELL_Y, cy);
		write_reg(REG_ORIG_X, gx);
		write_reg(REG_ORIG_Y, gy);
		write_reg(REG_OFFS_X, ox);
		write_reg(REG_OFFS_Y, oy);
		write_reg(REG_OFFS_Z, oz);
		write_reg(REG_MAXP, mp);
	endtask

	function automatic logic [31:0] rand_word();
		return $urandom();
	endfunction

	// A well-formed request: source well above the detector tops, plane near
	// them, and a box a few pitches wide somewhere over the grid, so that the
	// walk visits real cells with gaps and sometimes hits the polygon budget.
	function automatic req_t sane_request();
		req_t   rq;
		longint cx, cy, x0, y0;
		cx = pitch_x == 0 ? 1 : longint'(pitch_x);
		cy = pitch_y == 0 ? 1 : longint'(pitch_y);
		rq.src_z = 32'(longint'(offset_z) + longint'($urandom_range(200, 20)) * 65536
			+ $urandom_range(65535));
		rq.plane_z = 32'(longint'(offset_z) + longint'($urandom_range(8)) * 16384
			- 65536);
		rq.src_x = 32'(longint'(origin_x) + longint'($urandom_range(130)) * cx
			+ $urandom_range(65535));
		rq.src_y = 32'(longint'(origin_y) + longint'($urandom_range(130)) * cy
			+ $urandom_range(65535));
		x0 = longint'(origin_x) + (longint'($urandom_range(135)) - 4) * cx
			+ $urandom_range(65535);
		y0 = longint'(origin_y) + (longint'($urandom_range(135)) - 4) * cy
			+ $urandom_range(65535);
		rq.box_x_min = 32'(x0);
		rq.box_x_max = 32'(x0 + longint'($urandom_range(9)) * cx + $urandom_range(999));
		rq.box_y_min = 32'(y0);
		rq.box_y_max = 32'(y0 + longint'($urandom_range(7)) * cy + $urandom_range(999));
		return rq;
	endfunction

	function automatic req_t noise_request();
		req_t rq;
		rq = {rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word()};
		return rq;
	endfunction

	// Queue a batch of random requests: mostly well-formed, some pure noise.
	task automatic queue_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 75) begin
				requests_to_send.push_back(sane_request());
			end else begin
				requests_to_send.push_back(noise_request());
			end
		end
	endtask

	// Let every queued request go out and every expected result come back,
	// then give the back end time to settle before touching registers.
	task automatic drain();
		while (requests_to_send.size() != 0 || push || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	initial begin
		req_t rq;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		pop = 1'b0;
		drv = '0;
		req_taken = 1'b0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 35;
		recv_idle_pct = 78;
		pitch_x = 31'd65536;
		pitch_y = 31'd65536;
		origin_x = 0;
		origin_y = 0;
		offset_x = 0;
		offset_y = 0;
		offset_z = 0;
		poly_limit = 6'd63;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset register values.
		rq = '{default: 32'sh7FFFFFFF};
		requests_to_send.push_back(rq);
		rq = '{default: 32'sh80000000};
		requests_to_send.push_back(rq);
		rq = '0;
		requests_to_send.push_back(rq);
		// Source on the detector-top height: zero denominator.
		rq = sane_request();
		rq.src_z = offset_z;
		requests_to_send.push_back(rq);
		// Source on the projection plane: the other zero denominator.
		rq = sane_request();
		rq.plane_z = rq.src_z;
		requests_to_send.push_back(rq);
		// Box far below the grid: empty range.
		rq = sane_request();
		rq.box_x_min = 32'sh80000000;
		rq.box_x_max = -32'sd100000000;
		requests_to_send.push_back(rq);
		// Box beyond the top of the grid: empty range from the other side.
		rq = sane_request();
		rq.box_y_min = 32'sd200000000;
		rq.box_y_max = 32'sh7FFFFFFF;
		requests_to_send.push_back(rq);
		// Box over most of the grid: the walk runs out of its budget.
		rq = sane_request();
		rq.box_x_min = 0;
		rq.box_x_max = 32'sd8000000;
		rq.box_y_min = 0;
		rq.box_y_max = 32'sd8000000;
		requests_to_send.push_back(rq);
		// Box that spans a gap column and a gap row.
		rq = sane_request();
		rq.box_x_min = 32'sd15 * 65536;
		rq.box_x_max = 32'sd19 * 65536;
		rq.box_y_min = 32'sd7 * 65536;
		rq.box_y_max = 32'sd10 * 65536;
		requests_to_send.push_back(rq);
		for (int k = 0; k < 6; k++) begin
			requests_to_send.push_back(sane_request());
		end
		queue_random(40);
		drain();

		// Smallest pitches, far-off origins and offsets, one polygon allowed.
		write_all(32'd1312, 32'd1312, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'd1);
		queue_random(45);
		drain();

		// Receiver now idles less than the sender.
		send_idle_pct = 78;
		recv_idle_pct = 35;
		// Zero pitch is taken as the smallest step; largest budget.
		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd63);
		queue_random(40);
		drain();

		// No polygons allowed at all: every request ends at once.
		write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_random(15);
		drain();

		// Random realistic geometry with a random budget.
		write_all($urandom_range(32'h30000, 1312), $urandom_range(32'h30000, 1312),
			32'($signed($urandom_range(2000000)) - 1000000),
			32'($signed($urandom_range(2000000)) - 1000000),
			32'($signed($urandom_range(2000000)) - 1000000),
			32'($signed($urandom_range(2000000)) - 1000000),
			32'($signed($urandom_range(2000000)) - 1000000),
			$urandom_range(63, 1));
		queue_random(50);
		drain();

		// Neither side idles; back to the reset values.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all(32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd63);
		queue_random(50);
		drain();
		write_all($urandom_range(32'h20000, 32'h8000), $urandom_range(32'h20000, 32'h8000),
			32'd0, 32'd0, 32'd0, 32'd0, 32'($signed($urandom_range(200000)) - 100000),
			$urandom_range(63, 1));
		queue_random(75);
		drain();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
